// ----- design/swsd_pkg.sv -----
// ----------------------------------------------------------------------------
// swsd_pkg: shared types and constants for the sync word sample deframer
// Sync bytes, status codes, register indexes and the stage structs.
// ----------------------------------------------------------------------------
package swsd_pkg;

   localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
   localparam logic [7:0]  SYNC_SECOND = 8'h5A;
   localparam logic [12:0] HOP_MAX     = 13'd4096;

   localparam logic [12:0] HOP_LENGTH_RESET = 13'd256;
   localparam logic [15:0] IDLE_LIMIT_RESET = 16'd1000;
   localparam logic [15:0] BYTE_LIMIT_RESET = 16'd300;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_HOP_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_LIMIT = 2'd2;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [1:0] STATUS_SAMPLE = 2'd0;
   localparam logic [1:0] STATUS_IDLE   = 2'd1;
   localparam logic [1:0] STATUS_ABORT  = 2'd2;

   typedef enum logic [1:0] {
      PHASE_HUNT_FIRST,
      PHASE_HUNT_SECOND,
      PHASE_LOW,
      PHASE_HIGH
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  low_byte;
      logic [11:0] sample_index;
      logic [15:0] silence_ticks;
   } state_type;

   typedef struct packed {
      logic [12:0] hop_length;
      logic [15:0] idle_limit;
      logic [15:0] byte_limit;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  status;
      logic [15:0] sample;
      logic        last_of_hop;
   } result_type;

endpackage

// ----- design/swsd_step.sv -----
// ----------------------------------------------------------------------------
// swsd_step: per-item update of the deframer
// Takes the current state, the registers and one item; gives the next state
// and the result, if any.
// ----------------------------------------------------------------------------
module swsd_step (
   input  swsd_pkg::state_type  state,
   input  swsd_pkg::cfg_type    cfg,
   input  logic                 kind,
   input  logic [7:0]           rx_byte,
   output swsd_pkg::state_type  state_next,
   output swsd_pkg::result_type result
);

   logic                 hunting;
   logic [15:0]          limit;
   logic [15:0]          ticks_inc;
   logic                 fire;
   logic [12:0]          done_count;
   logic [12:0]          eff_hop;
   logic                 hop_done;
   swsd_pkg::phase_type  phase_next;

   assign hunting   = (state.phase == swsd_pkg::PHASE_HUNT_FIRST) ||
                      (state.phase == swsd_pkg::PHASE_HUNT_SECOND);
   assign limit     = hunting ? cfg.idle_limit : cfg.byte_limit;
   assign ticks_inc = (state.silence_ticks == 16'hFFFF) ? state.silence_ticks
                                                        : state.silence_ticks + 16'd1;
   assign fire      = (ticks_inc >= limit);

   // zero acts as one, above the max clamps
   always_comb begin
      if (cfg.hop_length == 13'd0) begin
         eff_hop = 13'd1;
      end else if (cfg.hop_length > swsd_pkg::HOP_MAX) begin
         eff_hop = swsd_pkg::HOP_MAX;
      end else begin
         eff_hop = cfg.hop_length;
      end
   end

   assign done_count = {1'b0, state.sample_index} + 13'd1;
   assign hop_done   = (done_count >= eff_hop);

   // next phase
   always_comb begin
      phase_next = state.phase;
      if (kind == swsd_pkg::KIND_TICK) begin
         if (fire) begin
            phase_next = swsd_pkg::PHASE_HUNT_FIRST;
         end
      end else begin
         case (state.phase)
            swsd_pkg::PHASE_HUNT_FIRST: begin
               if (rx_byte == swsd_pkg::SYNC_FIRST) begin
                  phase_next = swsd_pkg::PHASE_HUNT_SECOND;
               end
            end
            swsd_pkg::PHASE_HUNT_SECOND: begin
               if (rx_byte == swsd_pkg::SYNC_SECOND) begin
                  phase_next = swsd_pkg::PHASE_LOW;
               end else if (rx_byte != swsd_pkg::SYNC_FIRST) begin
                  phase_next = swsd_pkg::PHASE_HUNT_FIRST;
               end
            end
            swsd_pkg::PHASE_LOW: begin
               phase_next = swsd_pkg::PHASE_HIGH;
            end
            swsd_pkg::PHASE_HIGH: begin
               phase_next = hop_done ? swsd_pkg::PHASE_HUNT_FIRST
                                     : swsd_pkg::PHASE_LOW;
            end
            default: begin
               phase_next = swsd_pkg::PHASE_HUNT_FIRST;
            end
         endcase
      end
   end

   // data state and result
   always_comb begin
      state_next.phase         = phase_next;
      state_next.low_byte      = state.low_byte;
      state_next.sample_index  = state.sample_index;
      state_next.silence_ticks = state.silence_ticks;
      result.valid       = 1'b0;
      result.status      = swsd_pkg::STATUS_SAMPLE;
      result.sample      = 16'd0;
      result.last_of_hop = 1'b0;
      if (kind == swsd_pkg::KIND_TICK) begin
         state_next.silence_ticks = ticks_inc;
         if (fire) begin
            state_next.sample_index  = 12'd0;
            state_next.silence_ticks = 16'd0;
            result.valid  = 1'b1;
            result.status = hunting ? swsd_pkg::STATUS_IDLE : swsd_pkg::STATUS_ABORT;
         end
      end else begin
         state_next.silence_ticks = 16'd0;
         case (state.phase)
            swsd_pkg::PHASE_HUNT_SECOND: begin
               if (rx_byte == swsd_pkg::SYNC_SECOND) begin
                  state_next.sample_index = 12'd0;
               end
            end
            swsd_pkg::PHASE_LOW: begin
               state_next.low_byte = rx_byte;
            end
            swsd_pkg::PHASE_HIGH: begin
               result.valid       = 1'b1;
               result.sample      = {rx_byte, state.low_byte};
               result.last_of_hop = hop_done;
               state_next.sample_index = hop_done ? 12'd0 : done_count[11:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ----- design/sync_word_sample_deframer.sv -----
// ----------------------------------------------------------------------------
// sync_word_sample_deframer: sync pair hunt, sample assembly, silence timeouts
// Top level with input register, state update and result register.
// ----------------------------------------------------------------------------
// Each transfer on req_ is a received byte (req_kind 0) or one 1 ms tick
// (req_kind 1). The block hunts for 0xA5 0x5A, then assembles hop_length
// little-endian 16-bit samples and sends each on rsp_ with status 0, marking
// the final one with rsp_last_of_hop. Ticks with no byte count up; while
// hunting, idle_limit of them give status 1, inside a hop byte_limit give
// status 2, and the hunt restarts. Items flow one per clock unless rsp_ready
// stalls: an item enters the input register, and from there the state update
// and the result register are written in one pass; a result stalled on
// rsp_ready holds the next item in the input register, whatever its kind,
// and req_ready falls once that register is full. Registers are to be written
// through csr_ only while no traffic is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module sync_word_sample_deframer (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic [7:0]                         req_rx_byte,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic signed [15:0]                 rsp_sample,
   output logic                               rsp_last_of_hop,

   input  logic                               csr_we,
   input  logic [swsd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [swsd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration registers
   swsd_pkg::cfg_type    cfg_ff;

   // input register
   logic                 item_valid_ff;
   logic                 item_kind_ff;
   logic [7:0]           item_byte_ff;

   // deframer state
   swsd_pkg::state_type  state_ff;
   swsd_pkg::state_type  state_in;

   // result register
   logic                 out_valid_ff;
   logic [1:0]           out_status_ff;
   logic [15:0]          out_sample_ff;
   logic                 out_last_ff;

   swsd_pkg::result_type result;
   logic                 advance;

   // The held item moves on once the result register is free or being read;
   // this also covers items that make no result.
   assign advance   = item_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hop_length <= swsd_pkg::HOP_LENGTH_RESET;
         cfg_ff.idle_limit <= swsd_pkg::IDLE_LIMIT_RESET;
         cfg_ff.byte_limit <= swsd_pkg::BYTE_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            swsd_pkg::CSR_HOP_LENGTH: cfg_ff.hop_length <= csr_wdata[12:0];
            swsd_pkg::CSR_IDLE_LIMIT: cfg_ff.idle_limit <= csr_wdata;
            swsd_pkg::CSR_BYTE_LIMIT: cfg_ff.byte_limit <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_kind_ff <= req_kind;
         item_byte_ff <= req_rx_byte;
      end
   end

   swsd_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .kind       (item_kind_ff),
      .rx_byte    (item_byte_ff),
      .state_next (state_in),
      .result     (result)
   );

   // state update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= swsd_pkg::PHASE_HUNT_FIRST;
         state_ff.low_byte      <= 8'd0;
         state_ff.sample_index  <= 12'd0;
         state_ff.silence_ticks <= 16'd0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && result.valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         out_status_ff <= result.status;
         out_sample_ff <= result.sample;
         out_last_ff   <= result.last_of_hop;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_sample      = out_sample_ff;
   assign rsp_last_of_hop = out_last_ff;

endmodule

// ----- test/tb_sync_word_sample_deframer.sv -----
// ----------------------------------------------------------------------------
// tb_sync_word_sample_deframer: self-checking bench for the sample deframer
// Streams bytes and 1 ms ticks into req_, predicts every sample, idle and
// abort status from a shadow of the hunt state, and checks each rsp_ transfer.
// ----------------------------------------------------------------------------
module tb_sync_word_sample_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   // Index 3 decodes to no register; writes there must be dropped.
   localparam logic [swsd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // Longest stretch with no transfer on either channel. Random gaps at 47%
   // per cycle never get near this; only a hung block does.
   localparam int STALL_LIMIT  = 2000;
   // Cycles to let byte-only items settle in the two-stage pipe.
   localparam int SETTLE_CYCLES = 4;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } rx_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] sample;
      logic        last_of_hop;
   } deframe_result_type;

   // ------------------------------------------------------------------------
   // Clock, reset and DUT
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   logic                                req_valid   = 1'b0;
   logic                                req_ready;
   logic                                req_kind    = swsd_pkg::KIND_BYTE;
   logic [7:0]                          req_rx_byte = 8'h00;

   logic                                rsp_valid;
   logic                                rsp_ready   = 1'b0;
   logic [1:0]                          rsp_status;
   logic signed [15:0]                  rsp_sample;
   logic                                rsp_last_of_hop;

   logic                                csr_we      = 1'b0;
   logic [swsd_pkg::CSR_INDEX_W-1:0]    csr_index   = swsd_pkg::CSR_HOP_LENGTH;
   logic [swsd_pkg::CSR_DATA_W-1:0]     csr_wdata   = '0;

   sync_word_sample_deframer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_sample      (rsp_sample),
      .rsp_last_of_hop (rsp_last_of_hop),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   rx_item_type        pending_items[$];     // filled by stimulus, drained by driver
   deframe_result_type expected_results[$];  // oldest first

   int send_gap_pct = 0;   // chance per cycle that the sender holds off
   int stall_pct    = 0;   // chance per cycle that the receiver stalls

   int items_queued   = 0;
   int items_accepted = 0;
   int quiet_cycles   = 0;
   int mismatches     = 0;
   int settings_written = 0;
   int samples_seen = 0, hop_ends_seen = 0, idles_seen = 0, aborts_seen = 0;

   // Shadow of the register file, updated on the same edge as the DUT.
   logic [12:0] hop_cfg  = swsd_pkg::HOP_LENGTH_RESET;
   logic [15:0] idle_cfg = swsd_pkg::IDLE_LIMIT_RESET;
   logic [15:0] byte_cfg = swsd_pkg::BYTE_LIMIT_RESET;

   // Shadow of the hunt/assembly state.
   swsd_pkg::phase_type hunt_phase   = swsd_pkg::PHASE_HUNT_FIRST;
   logic [7:0]          held_low     = 8'h00;
   logic [11:0]         samples_done = '0;
   logic [15:0]         quiet_ticks  = '0;

   // ------------------------------------------------------------------------
   // Predictor: advance the shadow state by one accepted transfer and queue
   // the status or sample it produces, if any.
   // ------------------------------------------------------------------------
   task automatic deframe_predict(input rx_item_type it);
      deframe_result_type res;
      logic               hunting;
      logic [15:0]        limit;
      logic [12:0]        target;
      logic [12:0]        done;
      res = '0;
      if (it.kind == swsd_pkg::KIND_TICK) begin
         // Silence counter saturates; the limit depends on hunting vs in-hop.
         // A limit of zero fires on the first tick, same as one.
         hunting = (hunt_phase == swsd_pkg::PHASE_HUNT_FIRST) ||
                   (hunt_phase == swsd_pkg::PHASE_HUNT_SECOND);
         limit   = hunting ? idle_cfg : byte_cfg;
         if (quiet_ticks != 16'hFFFF) quiet_ticks = quiet_ticks + 16'd1;
         if (quiet_ticks >= limit) begin
            res.status = hunting ? swsd_pkg::STATUS_IDLE : swsd_pkg::STATUS_ABORT;
            expected_results.push_back(res);
            hunt_phase   = swsd_pkg::PHASE_HUNT_FIRST;
            samples_done = '0;
            quiet_ticks  = '0;
         end
      end else begin
         quiet_ticks = '0;
         case (hunt_phase)
            swsd_pkg::PHASE_HUNT_FIRST: begin
               if (it.rx_byte == swsd_pkg::SYNC_FIRST) hunt_phase = swsd_pkg::PHASE_HUNT_SECOND;
            end
            swsd_pkg::PHASE_HUNT_SECOND: begin
               // A repeated first sync byte keeps the half-found pair.
               if (it.rx_byte == swsd_pkg::SYNC_SECOND) begin
                  hunt_phase   = swsd_pkg::PHASE_LOW;
                  samples_done = '0;
               end else if (it.rx_byte != swsd_pkg::SYNC_FIRST) begin
                  hunt_phase = swsd_pkg::PHASE_HUNT_FIRST;
               end
            end
            swsd_pkg::PHASE_LOW: begin
               held_low   = it.rx_byte;
               hunt_phase = swsd_pkg::PHASE_HIGH;
            end
            default: begin
               // Hop length 0 behaves as 1, anything past the max is clamped.
               if (hop_cfg == 13'd0) target = 13'd1;
               else if (hop_cfg > swsd_pkg::HOP_MAX) target = swsd_pkg::HOP_MAX;
               else target = hop_cfg;
               done   = {1'b0, samples_done} + 13'd1;
               res.status      = swsd_pkg::STATUS_SAMPLE;
               res.sample      = {it.rx_byte, held_low};
               res.last_of_hop = (done >= target);
               expected_results.push_back(res);
               if (res.last_of_hop) begin
                  hunt_phase   = swsd_pkg::PHASE_HUNT_FIRST;
                  samples_done = '0;
               end else begin
                  hunt_phase   = swsd_pkg::PHASE_LOW;
                  samples_done = done[11:0];
               end
            end
         endcase
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] MISMATCH %s", $time, msg);
   endtask

   // ------------------------------------------------------------------------
   // Driver: present the next pending item once the current one is taken.
   // Valid holds with a stable payload until the transfer happens.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      rx_item_type head;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
            head = pending_items.pop_front();
            req_valid   <= 1'b1;
            req_kind    <= head.kind;
            req_rx_byte <= head.rx_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: mirror register writes, predict on each req_ transfer, check
   // each rsp_ transfer against the oldest prediction, and feed the watchdog.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      deframe_result_type want;
      rx_item_type        seen;
      if (reset) begin
         hop_cfg      = swsd_pkg::HOP_LENGTH_RESET;
         idle_cfg     = swsd_pkg::IDLE_LIMIT_RESET;
         byte_cfg     = swsd_pkg::BYTE_LIMIT_RESET;
         hunt_phase   = swsd_pkg::PHASE_HUNT_FIRST;
         held_low     = 8'h00;
         samples_done = '0;
         quiet_ticks  = '0;
         quiet_cycles <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               swsd_pkg::CSR_HOP_LENGTH: hop_cfg  = csr_wdata[12:0];
               swsd_pkg::CSR_IDLE_LIMIT: idle_cfg = csr_wdata;
               swsd_pkg::CSR_BYTE_LIMIT: byte_cfg = csr_wdata;
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            seen.kind    = req_kind;
            seen.rx_byte = req_rx_byte;
            deframe_predict(seen);
            items_accepted++;
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending: status %0d sample %0d",
                                         rsp_status, rsp_sample));
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d, want %0d",
                                            rsp_status, want.status));
               if (rsp_sample !== want.sample)
                  report_mismatch($sformatf("sample got %0d, want %0d",
                                            rsp_sample, $signed(want.sample)));
               if (rsp_last_of_hop !== want.last_of_hop)
                  report_mismatch($sformatf("last_of_hop got %0b, want %0b",
                                            rsp_last_of_hop, want.last_of_hop));
               case (want.status)
                  swsd_pkg::STATUS_SAMPLE: begin
                     samples_seen++;
                     if (want.last_of_hop) hop_ends_seen++;
                  end
                  swsd_pkg::STATUS_IDLE:  idles_seen++;
                  default:                aborts_seen++;
               endcase
            end
         end

         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_results.size());
      $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_item(input logic kind, input logic [7:0] b);
      rx_item_type item;
      item.kind    = kind;
      item.rx_byte = b;
      pending_items.push_back(item);
      items_queued++;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      send_gap_pct = (mode == IDLE_SENDER)   ? 47 : (mode == IDLE_BOTH) ? 33 : 0;
      stall_pct    = (mode == IDLE_RECEIVER) ? 47 : (mode == IDLE_BOTH) ? 33 : 0;
   endtask

   // Registers change only with the pipe empty; byte-only items leave no
   // result behind, so let them settle after the drain to clear the two stages.
   task automatic wait_drained();
      while (items_accepted != items_queued || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [swsd_pkg::CSR_INDEX_W-1:0] index,
                            input logic [swsd_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_written++;
   endtask

   // Mostly well-formed hops with random payload and stray ticks; the rest is
   // tick runs and noise. Truncated hops leave bytes that the next hunt sees.
   task automatic queue_traffic(input int budget, input int hop, input int tick_span);
      int start;
      int choice;
      int nbytes;
      start = items_queued;
      while (items_queued - start < budget) begin
         choice = $urandom_range(0, 9);
         if (choice < 7) begin
            repeat ($urandom_range(0, 2))
               push_item(swsd_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 3)) push_item(swsd_pkg::KIND_BYTE, swsd_pkg::SYNC_FIRST);
            push_item(swsd_pkg::KIND_BYTE, swsd_pkg::SYNC_SECOND);
            nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2 * hop) : 2 * hop;
            for (int i = 0; i < nbytes; i++) begin
               if ($urandom_range(0, 11) == 0)
                  repeat ($urandom_range(1, tick_span))
                     push_item(swsd_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
               push_item(swsd_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
            end
         end else if (choice == 7) begin
            repeat ($urandom_range(1, tick_span))
               push_item(swsd_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4))
               push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      int unsigned hop_set  [8];
      int unsigned idle_set [8];
      int unsigned byte_set [8];
      int unsigned span_set [8];

      hop_set  = '{1, 4, 3, 8, 2, 16, 5, 12};
      idle_set = '{1, 3, 65535, 2, 5, 4, 1, 6};
      byte_set = '{1, 2, 65535, 5, 1, 4, 65535, 3};
      span_set = '{2, 4, 6, 6, 6, 5, 3, 8};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset register values: sync hunt with a repeated first byte, then
      // sample extremes. The hop stays open (256 samples).
      set_idling(IDLE_NONE);
      push_item(swsd_pkg::KIND_BYTE, 8'h00);
      push_item(swsd_pkg::KIND_BYTE, swsd_pkg::SYNC_FIRST);
      push_item(swsd_pkg::KIND_BYTE, swsd_pkg::SYNC_FIRST);
      push_item(swsd_pkg::KIND_BYTE, swsd_pkg::SYNC_SECOND);
      push_item(swsd_pkg::KIND_BYTE, 8'h00);  push_item(swsd_pkg::KIND_BYTE, 8'h00);
      push_item(swsd_pkg::KIND_BYTE, 8'hFF);  push_item(swsd_pkg::KIND_BYTE, 8'hFF);
      push_item(swsd_pkg::KIND_BYTE, 8'h00);  push_item(swsd_pkg::KIND_BYTE, 8'h80);
      push_item(swsd_pkg::KIND_BYTE, 8'hFF);  push_item(swsd_pkg::KIND_BYTE, 8'h7F);
      push_item(swsd_pkg::KIND_TICK, 8'hFF);
      push_item(swsd_pkg::KIND_BYTE, 8'h12);  push_item(swsd_pkg::KIND_BYTE, 8'h34);
      wait_drained();

      // Zero hop length and zero limits; index 3 must not land anywhere.
      write_csr(swsd_pkg::CSR_HOP_LENGTH, 16'd0);
      write_csr(swsd_pkg::CSR_IDLE_LIMIT, 16'd0);
      write_csr(swsd_pkg::CSR_BYTE_LIMIT, 16'd0);
      write_csr(CSR_UNUSED, 16'h0007);
      set_idling(IDLE_BOTH);
      push_item(swsd_pkg::KIND_TICK, 8'h00);        // abort: still inside the open hop
      push_item(swsd_pkg::KIND_TICK, 8'h00);        // idle while hunting
      push_item(swsd_pkg::KIND_BYTE, swsd_pkg::SYNC_FIRST);
      push_item(swsd_pkg::KIND_TICK, 8'h00);        // idle with half the pair found
      push_item(swsd_pkg::KIND_BYTE, swsd_pkg::SYNC_FIRST);
      push_item(swsd_pkg::KIND_BYTE, swsd_pkg::SYNC_SECOND);
      push_item(swsd_pkg::KIND_BYTE, 8'h01);
      push_item(swsd_pkg::KIND_TICK, 8'h00);        // abort between low and high byte
      push_item(swsd_pkg::KIND_BYTE, swsd_pkg::SYNC_FIRST);
      push_item(swsd_pkg::KIND_BYTE, swsd_pkg::SYNC_SECOND);
      push_item(swsd_pkg::KIND_BYTE, 8'hCD);
      push_item(swsd_pkg::KIND_BYTE, 8'hAB);        // one-sample hop ends here
      wait_drained();

      // Hop length written with bits above the 13-bit field: only the low
      // bits count, so this gives two-sample hops. Limits at their max stay
      // quiet through a tick inside the hop.
      write_csr(swsd_pkg::CSR_HOP_LENGTH, 16'hE002);
      write_csr(swsd_pkg::CSR_IDLE_LIMIT, 16'hFFFF);
      write_csr(swsd_pkg::CSR_BYTE_LIMIT, 16'hFFFF);
      set_idling(IDLE_NONE);
      push_item(swsd_pkg::KIND_BYTE, swsd_pkg::SYNC_FIRST);
      push_item(swsd_pkg::KIND_BYTE, swsd_pkg::SYNC_SECOND);
      push_item(swsd_pkg::KIND_BYTE, 8'h01);
      push_item(swsd_pkg::KIND_TICK, 8'h00);
      push_item(swsd_pkg::KIND_BYTE, 8'h02);
      push_item(swsd_pkg::KIND_BYTE, 8'h03);
      push_item(swsd_pkg::KIND_BYTE, 8'h04);        // second sample closes the hop
      push_item(swsd_pkg::KIND_BYTE, swsd_pkg::SYNC_FIRST);
      push_item(swsd_pkg::KIND_BYTE, swsd_pkg::SYNC_SECOND);
      push_item(swsd_pkg::KIND_BYTE, 8'h11);
      push_item(swsd_pkg::KIND_BYTE, 8'h22);
      push_item(swsd_pkg::KIND_BYTE, 8'h33);
      push_item(swsd_pkg::KIND_BYTE, 8'h44);
      wait_drained();

      // Random phases, cycling through the idling patterns. Each phase pauses
      // the sender halfway until every pending result is back.
      for (int p = 0; p < 8; p++) begin
         write_csr(swsd_pkg::CSR_HOP_LENGTH, 16'(hop_set[p]));
         write_csr(swsd_pkg::CSR_IDLE_LIMIT, 16'(idle_set[p]));
         write_csr(swsd_pkg::CSR_BYTE_LIMIT, 16'(byte_set[p]));
         set_idling(idle_mode_type'(p % 4));
         queue_traffic(100, int'(hop_set[p]), int'(span_set[p]));
         wait_drained();
         queue_traffic(100, int'(hop_set[p]), int'(span_set[p]));
         wait_drained();
      end

      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

      $display("Run covered %0d input transfers across %0d register writes.",
               items_accepted, settings_written);
      $display("Checked %0d samples (%0d hop ends), %0d idle and %0d abort statuses.",
               samples_seen, hop_ends_seen, idles_seen, aborts_seen);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
